// ===== rtl/icr_pkg.sv =====
// icr_pkg: sizes, codes and shared types of the inverse-cdf resampler
// no dependencies; imported by the interfaces, icr_engine and inverse_cdf_resampler

package icr_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int FRACTION_BITS = 32;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int SUM_W         = FRACTION_BITS + 1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             overrun;
  } res_t;

endpackage

// ===== rtl/icr_if.sv =====
// icr_in_if and icr_out_if: valid/ready channels of the resampler
// depends on icr_pkg

interface icr_in_if import icr_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [FRACTION_BITS-1:0] weight;
  logic                     last_weight;
  logic [FRACTION_BITS-1:0] uniform_value;
  logic                     last_query;

  modport source (output valid, operation, weight, last_weight, uniform_value, last_query,
                  input ready);
  modport sink (input valid, operation, weight, last_weight, uniform_value, last_query,
                output ready);
endinterface

interface icr_out_if import icr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] particle_index;
  logic             overrun;

  modport source (output valid, particle_index, overrun, input ready);
  modport sink (input valid, particle_index, overrun, output ready);
endinterface

// ===== rtl/icr_ram.sv =====
// icr_ram: generic single write port, single read port ram, registered read
// no dependencies

module icr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/icr_engine.sv =====
// icr_engine: cumulative-sum table, load path and forward pointer scan
// depends on icr_pkg, icr_in_if and icr_ram

module icr_engine import icr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  icr_in_if.sink       request,
  input  logic         slot_free,
  output res_t         res
);

  state_t                   state;
  state_t                   state_next;
  logic [SUM_W-1:0]         total;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         ptr;
  logic                     complete;
  logic [FRACTION_BITS-1:0] u_reg;
  logic                     lastq_reg;

  logic                     fire;
  logic                     is_load;
  logic [CNT_W-1:0]         last_idx;
  logic [SUM_W:0]           sum_wide;
  logic [SUM_W-1:0]         sum_sat;
  logic                     we;
  logic [IDX_W-1:0]         raddr;
  logic [SUM_W-1:0]         rdata;
  logic                     above;
  logic                     more;
  logic                     finish;

  assign fire     = request.valid && request.ready;
  assign is_load  = op_t'(request.operation) == OP_LOAD;
  assign last_idx = count - CNT_W'(1);
  assign sum_wide = {1'b0, total} + {2'b0, request.weight};
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign we       = fire && is_load && !complete && !count[IDX_W];
  assign above    = {1'b0, u_reg} > rdata;
  assign more     = complete && ({1'b0, ptr} < last_idx) && above;
  assign finish   = (state == ST_SCAN) && !more && slot_free;

  icr_ram #(
    .DEPTH (MAX_PARTICLES),
    .WIDTH (SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata (sum_sat),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (fire && !is_load) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    request.ready = 1'b0;
    raddr         = ptr;
    res           = '0;
    unique case (state)
      ST_IDLE: begin
        request.ready = 1'b1;
      end
      ST_SCAN: begin
        if (more) begin
          raddr = ptr + IDX_W'(1);
        end
        res.valid   = finish;
        res.index   = complete ? ptr : '0;
        res.overrun = complete ? above : 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      total    <= '0;
      count    <= '0;
      ptr      <= '0;
      complete <= 1'b0;
    end else begin
      state <= state_next;
      if (fire && is_load && !complete) begin
        if (!count[IDX_W]) begin
          total <= sum_sat;
          count <= count + CNT_W'(1);
        end
        if (request.last_weight) begin
          complete <= 1'b1;
        end
      end
      if (state == ST_SCAN && more) begin
        ptr <= ptr + IDX_W'(1);
      end
      if (finish && lastq_reg) begin
        total    <= '0;
        count    <= '0;
        ptr      <= '0;
        complete <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_load) begin
      u_reg     <= request.uniform_value;
      lastq_reg <= request.last_query;
    end
  end

`ifndef SYNTHESIS
  a_ptr_in_table: assert property (@(posedge clk) disable iff (rst)
    complete |-> ({1'b0, ptr} <= last_idx))
    else $error("scan pointer beyond last loaded weight");

  a_ptr_idle_when_open: assert property (@(posedge clk) disable iff (rst)
    !complete |-> (ptr == '0))
    else $error("scan pointer moved while table incomplete");

  a_load_after_complete: assert property (@(posedge clk) disable iff (rst)
    (fire && is_load && complete) |=> (count == $past(count) && total == $past(total)))
    else $error("load changed a completed table");

  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_SCAN && slot_free))
    else $error("result outside scan or into a full slot");
`endif

endmodule

// ===== rtl/inverse_cdf_resampler.sv =====
// inverse_cdf_resampler: top level, engine plus output register
// depends on icr_pkg, icr_if and icr_engine

// Weights load one per item into a 1024-entry cumulative sum ram
// (saturating at 33 bits); a load carries no result. A query moves the scan
// pointer forward, up to the last loaded entry, past each entry below its
// uniform value: the pointer reads one ram entry per cycle through the
// single registered read port. Over a run with sorted uniforms the total
// advance is bounded by the number of weights. The input takes a new item
// while a result waits in the output register; a finished scan holds only
// if that register is still full.

module inverse_cdf_resampler import icr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  icr_in_if.sink   request,
  icr_out_if.source result
);

  res_t             res;
  logic             slot_free;
  logic             out_valid;
  logic [IDX_W-1:0] out_index;
  logic             out_overrun;

  assign slot_free = !out_valid || result.ready;

  icr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .slot_free (slot_free),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_index   <= res.index;
      out_overrun <= res.overrun;
    end
  end

  assign result.valid          = out_valid;
  assign result.particle_index = out_index;
  assign result.overrun        = out_overrun;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for the inverse-cdf resampler, weight loads with sorted and random queries
// predicts particle index and overrun per query and compares them item by item
// depends on icr_pkg, icr_if and the inverse_cdf_resampler rtl

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import icr_pkg::*;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int TAIL_ITEMS     = 100;
  localparam int RANDOM_ITEMS   = 900;
  localparam longint unsigned U_SPAN_MAX = 64'h1_0000_0000;

  typedef struct {
    op_t                      op;
    logic [FRACTION_BITS-1:0] weight;
    logic                     last_weight;
    logic [FRACTION_BITS-1:0] uniform_value;
    logic                     last_query;
  } req_item_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    logic             overrun;
  } pick_t;

  logic clk;
  logic rst;

  icr_in_if  req_if ();
  icr_out_if res_if ();

  inverse_cdf_resampler DUT (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  req_item_t pending_items [$];
  pick_t     expected_picks [$];
  req_item_t cur_item;
  logic      holding;
  int        src_gap;
  int        snk_gap;
  logic      src_idle;
  logic      snk_idle;
  int        mismatches;
  int        quiet_cycles;
  int        stim_count;

  logic [SUM_W-1:0] cdf_table [MAX_PARTICLES];
  logic [SUM_W-1:0] cdf_total;
  int unsigned      cdf_count;
  int unsigned      scan_ptr;
  logic             cdf_ready;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_cdf();
    cdf_total = '0;
    cdf_count = 0;
    scan_ptr  = 0;
    cdf_ready = 1'b0;
  endtask

  task automatic resample_step(input req_item_t it);
    logic [SUM_W:0] s;
    int unsigned    top_idx;
    pick_t          p;
    if (it.op == OP_LOAD) begin
      if (!cdf_ready) begin
        if (cdf_count < MAX_PARTICLES) begin
          s = {1'b0, cdf_total} + {2'b00, it.weight};
          cdf_total = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
          cdf_table[cdf_count[IDX_W-1:0]] = cdf_total;
          cdf_count++;
        end
        if (it.last_weight && cdf_count > 0) cdf_ready = 1'b1;
      end
    end else begin
      p.index   = '0;
      p.overrun = 1'b1;
      if (cdf_ready) begin
        top_idx = cdf_count - 1;
        if (scan_ptr > top_idx) scan_ptr = top_idx;
        while (scan_ptr < top_idx &&
               {1'b0, it.uniform_value} > cdf_table[scan_ptr[IDX_W-1:0]])
          scan_ptr++;
        p.overrun = ({1'b0, it.uniform_value} > cdf_table[scan_ptr[IDX_W-1:0]]);
        p.index   = scan_ptr[IDX_W-1:0];
      end
      expected_picks.push_back(p);
      if (it.last_query) clear_cdf();
    end
  endtask

  task automatic push_load(input logic [FRACTION_BITS-1:0] w, input logic lw,
                           input logic counted);
    req_item_t it;
    it.op            = OP_LOAD;
    it.weight        = w;
    it.last_weight   = lw;
    it.uniform_value = $urandom;
    it.last_query    = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
    if (counted) stim_count++;
  endtask

  task automatic push_query(input logic [FRACTION_BITS-1:0] u, input logic lq);
    req_item_t it;
    it.op            = OP_QUERY;
    it.weight        = $urandom;
    it.last_weight   = 1'($urandom_range(0, 1));
    it.uniform_value = u;
    it.last_query    = lq;
    pending_items.push_back(it);
    stim_count++;
  endtask

  // loads a table, then mostly rising queries spread over its total plus an eighth
  task automatic push_run(input int nw, input int nq, input int shift, input logic lq_rand);
    longint unsigned sum;
    longint unsigned span;
    longint unsigned u;
    longint unsigned stepv;
    logic [FRACTION_BITS-1:0] w;
    logic lq;
    sum = 0;
    for (int i = 0; i < nw; i++) begin
      w = $urandom >> shift;
      if ($urandom_range(0, 9) == 0) w = '0;
      sum += 64'(w);
      push_load(w, i == nw - 1, 1'b1);
    end
    if ($urandom_range(0, 7) == 0) push_load($urandom, 1'($urandom_range(0, 1)), 1'b0);
    span = sum + sum / 8 + 2;
    if (span > U_SPAN_MAX) span = U_SPAN_MAX;
    stepv = span / 64'(nq);
    u = 0;
    for (int j = 0; j < nq; j++) begin
      u += {$urandom, $urandom} % (2 * stepv + 1);
      if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
      lq = lq_rand ? ($urandom_range(0, 3) == 0) : (j == nq - 1);
      if ($urandom_range(0, 11) == 0) push_query(u[31:0] >> 1, lq);
      else push_query(u[31:0], lq);
    end
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) push_query($urandom, 1'($urandom_range(0, 1)));
      else push_load($urandom, 1'($urandom_range(0, 1)), 1'b1);
    end
    push_query($urandom, 1'b1);
  endtask

  initial begin
    int r;
    int full_at;
    logic full_done;
    rst = 1'b1;
    req_if.valid         = 1'b0;
    req_if.operation     = OP_LOAD;
    req_if.weight        = '0;
    req_if.last_weight   = 1'b0;
    req_if.uniform_value = '0;
    req_if.last_query    = 1'b0;
    res_if.ready         = 1'b0;
    holding    = 1'b0;
    src_gap    = 0;
    snk_gap    = 0;
    src_idle   = 1'b1;
    snk_idle   = 1'b1;
    mismatches = 0;
    stim_count = 0;
    clear_cdf();

    // query before any table, partial table cleared by a last query
    push_query(32'hFFFF_FFFF, 1'b0);
    push_load(32'd7, 1'b0, 1'b1);
    push_query(32'h0, 1'b1);
    // saturating total, load after completion is dropped
    push_load(32'hFFFF_FFFF, 1'b0, 1'b1);
    push_load(32'hFFFF_FFFF, 1'b0, 1'b1);
    push_load(32'hFFFF_FFFF, 1'b1, 1'b1);
    push_load(32'd12345, 1'b1, 1'b1);
    push_query(32'h0, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b1);
    // zero weights, exact hits, value above total, decreasing value
    push_load(32'h0, 1'b0, 1'b1);
    push_load(32'h10, 1'b0, 1'b1);
    push_load(32'h0, 1'b1, 1'b1);
    push_query(32'h0, 1'b0);
    push_query(32'h1, 1'b0);
    push_query(32'h10, 1'b0);
    push_query(32'h11, 1'b0);
    push_query(32'h0, 1'b0);
    push_query(32'hFFFF_FFFF, 1'b1);
    // single entry table
    push_load(32'h0, 1'b1, 1'b1);
    push_query(32'h0, 1'b0);
    push_query(32'h1, 1'b1);

    stim_count = 0;
    full_at    = $urandom_range(200, 600);
    full_done  = 1'b0;
    while (stim_count < RANDOM_ITEMS) begin
      if (!full_done && stim_count >= full_at) begin
        full_done = 1'b1;
        r = stim_count;
        push_run(MAX_PARTICLES + 6, 20, 10, 1'b0);
        stim_count = r;
      end
      r = $urandom_range(0, 99);
      if (r < 60) push_run($urandom_range(1, 12), $urandom_range(1, 10),
                           $urandom_range(0, 28), 1'b0);
      else if (r < 70) push_run($urandom_range(13, 64), $urandom_range(1, 10),
                                $urandom_range(0, 28), 1'b0);
      else if (r < 80) begin
        for (int i = $urandom_range(1, 5); i > 0; i--) push_load($urandom, 1'b0, 1'b1);
        if ($urandom_range(0, 1)) push_query($urandom, 1'b0);
        push_query($urandom, 1'b1);
      end else if (r < 90) begin
        push_run($urandom_range(1, 12), $urandom_range(2, 10), $urandom_range(0, 28), 1'b1);
        push_query($urandom, 1'b1);
      end else push_noise($urandom_range(1, 6));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || holding || expected_picks.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (holding && req_if.ready) begin
        resample_step(cur_item);
        holding = 1'b0;
      end
      if (!holding) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_items.size() > 0) begin
          if (src_idle && pending_items.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
            src_gap = $urandom_range(0, 2);
          end else begin
            cur_item = pending_items.pop_front();
            holding  = 1'b1;
          end
        end
      end
      if ($urandom_range(0, 63) == 0) src_idle = !src_idle;
      req_if.valid         <= holding;
      req_if.operation     <= cur_item.op;
      req_if.weight        <= cur_item.weight;
      req_if.last_weight   <= cur_item.last_weight;
      req_if.uniform_value <= cur_item.uniform_value;
      req_if.last_query    <= cur_item.last_query;
    end
  end

  always @(posedge clk) begin
    pick_t p;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_picks.size() == 0) begin
          $display("%0t unexpected result: index %0d overrun %0b",
                   $realtime, res_if.particle_index, res_if.overrun);
          mismatches++;
        end else begin
          p = expected_picks.pop_front();
          if (res_if.particle_index !== p.index) begin
            $display("%0t particle_index mismatch: expected %0d, actual %0d",
                     $realtime, p.index, res_if.particle_index);
            mismatches++;
          end
          if (res_if.overrun !== p.overrun) begin
            $display("%0t overrun mismatch: expected %0b, actual %0b",
                     $realtime, p.overrun, res_if.overrun);
            mismatches++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        res_if.ready <= 1'b0;
      end else if (snk_idle && pending_items.size() > TAIL_ITEMS &&
                   $urandom_range(0, 3) == 0) begin
        snk_gap = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) snk_idle = !snk_idle;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
